// ----- rtl/dda_pkg.sv -----
// shared constants for the dda line rasterizer
package dda_pkg;

  localparam int COORD_BITS    = 10;
  localparam int FRAC_BITS_DEF = 16;

  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

endpackage

// ----- rtl/dda_line_rasterizer.sv -----
// dda line rasterizer top level: sequencer, accumulators and output register
//
// A start transfer (tuser = 0) carries two endpoints and returns the first pixel at once; for a
// line that is not a single point the block then holds s_tready low while the shared divider
// works out the minor-axis slope one quotient bit per cycle. A step transfer (tuser = 1)
// returns the next pixel, with tlast on the line's final endpoint; a step with no active line
// repeats the last pixel with m_tuser set. The output register lets a new transfer in while the
// previous result is taken.
module dda_line_rasterizer #(
  parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dda_pkg::IN_DATA_W-1:0]  s_tdata,  // x_start, y_start, x_end, y_end
  input  logic                           s_tuser,  // func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dda_pkg::OUT_DATA_W-1:0] m_tdata,  // pixel_x, pixel_y, zero pad
  output logic                           m_tuser,  // no_line
  output logic                           m_tlast   // last_pixel
);
  import dda_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int ACC = COORD_BITS + FRAC_BITS + 1;
  localparam logic [ACC-1:0] ONE  = ACC'(1) << FRAC_BITS;
  localparam logic [ACC-1:0] HALF = ACC'(1) << (FRAC_BITS - 1);

  typedef enum logic {IDLE, DIV} state_t;

  state_t         state;
  logic [ACC-1:0] x_accum, y_accum, x_increment, y_increment;
  logic [C-1:0]   steps_left;
  logic           line_active;
  logic           x_major, minor_neg;

  logic [C-1:0]   xs, ys, xe, ye;
  logic [C:0]     dx, dy;
  logic [C-1:0]   adx, ady;
  logic           take;
  logic           degen, xmaj;
  logic [ACC-1:0] x_accum_next, y_accum_next;
  logic [C-1:0]   steps_dec;
  logic [ACC-1:0] x_round, y_round;
  logic           last_next, none_next;

  logic           div_start, div_busy;
  logic [FRAC_BITS:0] quo;
  logic [ACC-1:0] minor_mag, minor_inc;

  assign xs = s_tdata[C-1:0];
  assign ys = s_tdata[2*C-1:C];
  assign xe = s_tdata[3*C-1:2*C];
  assign ye = s_tdata[4*C-1:3*C];

  assign s_tready = (state == IDLE) && (!m_tvalid || m_tready);
  assign take     = s_tvalid && s_tready;

  always_comb begin
    dx        = {1'b0, xe} - {1'b0, xs};
    dy        = {1'b0, ye} - {1'b0, ys};
    adx       = dx[C] ? C'(-dx) : dx[C-1:0];
    ady       = dy[C] ? C'(-dy) : dy[C-1:0];
    degen     = (adx == '0) && (ady == '0);
    xmaj      = (ady <= adx);
    div_start = take && (s_tuser == FUNC_START) && !degen;
    steps_dec = steps_left - 1'b1;
  end

  always_comb begin
    x_accum_next = x_accum;
    y_accum_next = y_accum;
    last_next    = 1'b0;
    none_next    = 1'b0;
    if (s_tuser == FUNC_START) begin
      x_accum_next = ACC'(xs) << FRAC_BITS;
      y_accum_next = ACC'(ys) << FRAC_BITS;
      last_next    = degen;
    end else if (line_active) begin
      x_accum_next = x_accum + x_increment;
      y_accum_next = y_accum + y_increment;
      last_next    = (steps_dec == '0);
    end else begin
      none_next = 1'b1;
    end
    x_round = x_accum_next + HALF;
    y_round = y_accum_next + HALF;
  end

  assign minor_mag = ACC'(quo);
  assign minor_inc = minor_neg ? -minor_mag : minor_mag;

  dda_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (xmaj ? ady : adx),
    .den   (xmaj ? adx : ady),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      x_accum     <= '0;
      y_accum     <= '0;
      x_increment <= '0;
      y_increment <= '0;
      steps_left  <= '0;
      line_active <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (take) begin
            x_accum  <= x_accum_next;
            y_accum  <= y_accum_next;
            if (s_tuser == FUNC_START) begin
              steps_left  <= xmaj ? adx : ady;
              line_active <= !degen;
              if (degen) begin
                x_increment <= '0;
                y_increment <= '0;
              end else begin
                state <= DIV;
                if (xmaj) begin
                  x_increment <= dx[C] ? -ONE : ONE;
                end else begin
                  y_increment <= dy[C] ? -ONE : ONE;
                end
              end
            end else if (line_active) begin
              steps_left <= steps_dec;
              if (steps_dec == '0) begin
                line_active <= 1'b0;
              end
            end
          end
        end
        DIV: begin
          if (!div_busy) begin
            state <= IDLE;
            if (x_major) begin
              y_increment <= minor_inc;
            end else begin
              x_increment <= minor_inc;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= OUT_DATA_W'({y_round[FRAC_BITS+C-1:FRAC_BITS],
                              x_round[FRAC_BITS+C-1:FRAC_BITS]});
      m_tlast <= last_next;
      m_tuser <= none_next;
      if (s_tuser == FUNC_START) begin
        x_major   <= xmaj;
        minor_neg <= xmaj ? dy[C] : dx[C];
      end
    end
  end

endmodule

// ----- rtl/dda_divider.sv -----
// restoring fixed-point divider, one quotient bit per cycle
module dda_divider #(
  parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dda_pkg::COORD_BITS-1:0] mag,
  input  logic [dda_pkg::COORD_BITS-1:0] den,
  output logic                           busy,
  output logic [FRAC_BITS:0]             quo
);
  import dda_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] den_q;
  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS:0]   opa;
  logic [COORD_BITS:0]   opb;
  logic [COORD_BITS+1:0] diff;
  logic                  ge;

  // shared compare and subtract
  always_comb begin
    if (start) begin
      opa = {1'b0, mag};
      opb = {1'b0, den};
    end else begin
      opa = {rem, 1'b0};
      opb = {1'b0, den_q};
    end
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = ~diff[COORD_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(FRAC_BITS - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      rem   <= ge ? diff[COORD_BITS-1:0] : opa[COORD_BITS-1:0];
      quo   <= {{FRAC_BITS{1'b0}}, ge};
    end else if (busy) begin
      rem <= ge ? diff[COORD_BITS-1:0] : opa[COORD_BITS-1:0];
      quo <= {quo[FRAC_BITS-1:0], ge};
    end
  end

endmodule

// ----- rtl/dda_checker.sv -----
// port-level checks for the dda line rasterizer
module dda_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [dda_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                           s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [dda_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);
  import dda_pkg::*;

  localparam int C = COORD_BITS;

  // input side only opens when the result slot is free or being emptied
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("input ready while output slot is held");

  // every transfer in yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted transfer gave no result");

  // first pixel of a line is its start point
  a_first_pixel: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == FUNC_START) |=>
      (m_tdata[C-1:0] == $past(s_tdata[C-1:0]) &&
       m_tdata[2*C-1:C] == $past(s_tdata[2*C-1:C]) && !m_tuser))
    else $error("first pixel differs from start point");

  // a repeated pixel never ends a line
  a_no_line_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser && m_tlast))
    else $error("no_line and last_pixel both set");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- tb/tb_dda_line_rasterizer.sv -----
// self-checking testbench for the dda line rasterizer: directed and random streams checked against a pixel predictor

typedef struct packed {
  logic [dda_pkg::COORD_BITS-1:0] px;
  logic [dda_pkg::COORD_BITS-1:0] py;
  logic                           last;
  logic                           none;
} pixel_t;

class raster_scoreboard;
  localparam int CW = dda_pkg::COORD_BITS;
  localparam int FB = dda_pkg::FRAC_BITS_DEF;
  localparam int AW = CW + FB + 1;
  localparam logic signed [AW-1:0] ONE  = AW'(1) << FB;
  localparam logic signed [AW:0]   HALF = (AW+1)'(1) << (FB - 1);

  logic signed [AW-1:0] x_acc, y_acc, x_inc, y_inc;
  logic [CW-1:0]        steps_left;
  bit                   active;
  pixel_t               pending[$];
  int                   errors;

  function new();
    x_acc      = '0;
    y_acc      = '0;
    x_inc      = '0;
    y_inc      = '0;
    steps_left = '0;
    active     = 1'b0;
    errors     = 0;
  endfunction

  function void report(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endfunction

  // floor(acc + 1/2) in whole pixels
  function logic [CW-1:0] round_coord(logic signed [AW-1:0] acc);
    logic signed [AW:0] v;
    logic signed [AW:0] q;
    v = acc + HALF;
    q = v >>> FB;
    return q[CW-1:0];
  endfunction

  // minor delta over |major delta|, truncated toward zero
  function logic signed [AW-1:0] slope(int delta, int major);
    longint mag;
    longint den;
    longint q;
    mag = (delta < 0) ? -delta : delta;
    den = (major < 0) ? -major : major;
    q   = (mag << FB) / den;
    return AW'((delta < 0) ? -q : q);
  endfunction

  function void note_input(logic f, logic [CW-1:0] xs, logic [CW-1:0] ys,
                           logic [CW-1:0] xe, logic [CW-1:0] ye);
    int     dx, dy, adx, ady, n;
    pixel_t p;
    p.last = 1'b0;
    p.none = 1'b0;
    if (f == dda_pkg::FUNC_START) begin
      dx    = int'(xe) - int'(xs);
      dy    = int'(ye) - int'(ys);
      adx   = (dx < 0) ? -dx : dx;
      ady   = (dy < 0) ? -dy : dy;
      x_acc = $signed({1'b0, xs, {FB{1'b0}}});
      y_acc = $signed({1'b0, ys, {FB{1'b0}}});
      if (adx == 0 && ady == 0) begin
        x_inc = '0;
        y_inc = '0;
        n     = 0;
      end else if (ady <= adx) begin
        x_inc = (dx > 0) ? ONE : -ONE;
        y_inc = slope(dy, dx);
        n     = adx;
      end else begin
        y_inc = (dy > 0) ? ONE : -ONE;
        x_inc = slope(dx, dy);
        n     = ady;
      end
      steps_left = CW'(n);
      active     = (steps_left != 0);
      p.last     = !active;
    end else if (active) begin
      x_acc      = x_acc + x_inc;
      y_acc      = y_acc + y_inc;
      steps_left = steps_left - 1'b1;
      if (steps_left == 0) begin
        active = 1'b0;
        p.last = 1'b1;
      end
    end else begin
      p.none = 1'b1;
    end
    p.px = round_coord(x_acc);
    p.py = round_coord(y_acc);
    pending.push_back(p);
  endfunction

  function void check_result(logic [CW-1:0] px, logic [CW-1:0] py, logic last, logic none);
    pixel_t e;
    if (pending.size() == 0) begin
      report($sformatf("pixel (%0d,%0d) with no transfer pending", px, py));
      return;
    end
    e = pending.pop_front();
    if (px !== e.px) report($sformatf("pixel_x got %0d want %0d", px, e.px));
    if (py !== e.py) report($sformatf("pixel_y got %0d want %0d", py, e.py));
    if (last !== e.last) report($sformatf("last_pixel got %b want %b", last, e.last));
    if (none !== e.none) report($sformatf("no_line got %b want %b", none, e.none));
  endfunction
endclass

module tb_dda_line_rasterizer;
  localparam int CW        = dda_pkg::COORD_BITS;
  localparam int MAX_COORD = (1 << CW) - 1;
  localparam int NUM_ITEMS = 1250;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [dda_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [dda_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tuser;
  logic                           m_tlast;

  raster_scoreboard sb = new();
  bit               quiet;
  int               sent;
  int               hold;
  int               r;

  dda_line_rasterizer DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #24000000;
    $display("Mismatches found");
    $finish;
  end

  // alternate stretches with and without idling
  initial begin
    quiet <= 1'b0;
    forever begin
      repeat ($urandom_range(300, 900)) @(posedge clk);
      quiet <= 1'b1;
      repeat ($urandom_range(100, 300)) @(posedge clk);
      quiet <= 1'b0;
    end
  end

  // output backpressure
  initial begin
    m_tready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        if (!quiet) begin
          r = $urandom_range(0, 99);
          if (r < 20) hold = $urandom_range(1, 3);
          else if (r < 24) hold = $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_input(s_tuser, s_tdata[CW-1:0], s_tdata[2*CW-1:CW],
                      s_tdata[3*CW-1:2*CW], s_tdata[4*CW-1:3*CW]);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata[CW-1:0], m_tdata[2*CW-1:CW], m_tlast, m_tuser);
    end
  end

  function automatic int pick_gap();
    int g;
    g = $urandom_range(0, 99);
    if (quiet || g < 55) return 0;
    if (g < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic f, input logic [CW-1:0] xs, input logic [CW-1:0] ys,
                           input logic [CW-1:0] xe, input logic [CW-1:0] ye);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {ye, xe, ys, xs};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // step fields carry junk, the block must ignore it
  task automatic send_step();
    send_item(dda_pkg::FUNC_STEP, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
  endtask

  task automatic run_line(input int xs, input int ys, input int xe, input int ye, input int n);
    send_item(dda_pkg::FUNC_START, CW'(xs), CW'(ys), CW'(xe), CW'(ye));
    repeat (n) send_step();
  endtask

  task automatic random_line();
    int xs, ys, xe, ye, maj, mnr, dx, dy, steps, n, k;
    bit x_major;
    xs = $urandom_range(0, MAX_COORD);
    ys = $urandom_range(0, MAX_COORD);
    if ($urandom_range(0, 99) < 85) begin
      maj     = $urandom_range(1, 40);
      x_major = $urandom_range(0, 1);
      if (x_major) mnr = ($urandom_range(0, 99) < 10) ? maj : $urandom_range(0, maj);
      else mnr = $urandom_range(0, maj - 1);
      if ($urandom_range(0, 1)) maj = -maj;
      if ($urandom_range(0, 1)) mnr = -mnr;
      dx = x_major ? maj : mnr;
      dy = x_major ? mnr : maj;
      xe = xs + dx;
      ye = ys + dy;
      if (xe < 0 || xe > MAX_COORD) xe = xs - dx;
      if (ye < 0 || ye > MAX_COORD) ye = ys - dy;
    end else begin
      xe = $urandom_range(0, MAX_COORD);
      ye = $urandom_range(0, MAX_COORD);
    end
    dx    = (xe > xs) ? xe - xs : xs - xe;
    dy    = (ye > ys) ? ye - ys : ys - ye;
    steps = (dx > dy) ? dx : dy;
    k     = $urandom_range(0, 99);
    if (steps > 60) n = $urandom_range(0, 30);
    else if (k < 80 || steps == 0) n = steps;
    else if (k < 90) n = steps + $urandom_range(1, 3);
    else n = $urandom_range(0, steps - 1);
    run_line(xs, ys, xe, ye, n);
  endtask

  initial begin
    int kind, pt_x, pt_y;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= 1'b0;
    s_tdata  <= '0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_step();                                   // no line after reset
    run_line(0, 0, 0, 0, 0);                       // degenerate at origin
    run_line(0, 0, MAX_COORD, MAX_COORD, 2);       // full diagonal, abandoned
    run_line(MAX_COORD, 0, 0, MAX_COORD, 2);       // anti-diagonal, abandoned
    run_line(5, 3, 5, 7, 5);                       // vertical plus one step past the end
    run_line(10, 10, 7, 10, 3);                    // horizontal leftward
    run_line(2, 2, 4, 4, 2);                       // slope exactly +1
    run_line(4, 2, 2, 4, 2);                       // slope exactly -1
    run_line(0, 0, 3, 10, 10);                     // steep
    run_line(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 1);

    // random part
    while (sent < NUM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_step();
      end else if (kind < 12) begin
        pt_x = $urandom_range(0, MAX_COORD);
        pt_y = $urandom_range(0, MAX_COORD);
        run_line(pt_x, pt_y, pt_x, pt_y, $urandom_range(0, 1));
      end else begin
        random_line();
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
